// ===== design/assert_macros.svh =====
// assertion macros used by the codec top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/b64x_pkg.sv =====
// types, constants and alphabet functions of the base64 xor escape codec
`default_nettype none

package b64x_pkg;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] KEY_RESET = 8'd109;

  localparam int NUM_SLOTS = 6;
  localparam int NUM_CHARS = 4;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef enum logic [0:0] {
    CFG_DIRECTION = 1'b0,
    CFG_MASK_KEY  = 1'b1
  } cfg_idx_e;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
  } res_t;

  // all results of one input item
  typedef struct packed {
    res_t [NUM_SLOTS-1:0] slot;
    logic [2:0]           cnt;
  } res_list_t;

  // up to four characters or bytes from one step, before escaping
  typedef struct packed {
    logic [NUM_CHARS-1:0][7:0] ch;
    logic [2:0]                cnt;
  } char_list_t;

  // hc is the held bit count divided by two
  typedef struct packed {
    logic [1:0] hc;
    logic [5:0] held;
    logic       esc;
  } codec_state_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      c = v8 + 8'h41;
    end else if (v < 6'd52) begin
      c = v8 + 8'h47;
    end else if (v < 6'd62) begin
      c = v8 - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic sextet_t b64_value(logic [7:0] c);
    sextet_t    s;
    logic [7:0] diff;
    s.ok  = 1'b1;
    diff  = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      diff = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff = c + 8'd4;
    end else if (c == 8'h2B) begin
      diff = 8'd62;
    end else if (c == 8'h2F) begin
      diff = 8'd63;
    end else begin
      s.ok = 1'b0;
    end
    s.val = diff[5:0];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64x_in_if.sv =====
// input channel: one byte or text character per item
`default_nettype none

interface b64x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== design/b64x_out_if.sv =====
// output channel: one produced character or decoded byte per item
`default_nettype none

interface b64x_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                output ready);
endinterface

`default_nettype wire

// ===== design/base64_xor_escape_codec.sv =====
// top level of the base64 codec with xor key mask and backslash escaping
//
// channel   dir  payload                       item
// in_if     in   in_byte[7:0], in_last         message byte or stored text char
// out_if    out  out_byte[7:0], out_valid,     text char or decoded byte
//                out_last
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i  direction / mask_key write
//
// an accepted item is held in the input register, then its 0 to 6 results
// are computed and loaded into the result bank at once
// the result bank sends one result per cycle while out_if.ready is high; items
// with zero or one result flow every cycle while the output is not stalled
// reset: encode mode, key 109, no held bits; the input register holds one
// item while the output is stalled
`default_nettype none
`include "assert_macros.svh"

module base64_xor_escape_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  b64x_in_if.sink             in_if,
  b64x_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  b64x_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);
  import b64x_pkg::*;

  dir_e         dir_q;
  logic [7:0]   key_q;
  codec_state_t st_q, st_d;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;

  logic         in_take;
  logic         step_fire;
  logic         buf_free;

  char_list_t   enc_chars, dec_chars, sel_chars;
  codec_state_t enc_st, dec_st;
  res_list_t    list;
  res_t         head;

  assign step_fire   = in_valid_q && buf_free;
  assign in_if.ready = !in_valid_q || step_fire;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_if.in_byte;
      in_last_q <= in_if.in_last;
    end
  end

  b64x_enc u_enc (
    .st_i    (st_q),
    .data_i  (in_byte_q),
    .last_i  (in_last_q),
    .key_i   (key_q),
    .chars_o (enc_chars),
    .st_o    (enc_st)
  );

  b64x_dec u_dec (
    .st_i    (st_q),
    .data_i  (in_byte_q),
    .last_i  (in_last_q),
    .key_i   (key_q),
    .chars_o (dec_chars),
    .st_o    (dec_st)
  );

  assign sel_chars = (dir_q == DIR_ENCODE) ? enc_chars : dec_chars;

  b64x_pack u_pack (
    .chars_i     (sel_chars),
    .escape_en_i (dir_q == DIR_ENCODE),
    .last_i      (in_last_q),
    .list_o      (list)
  );

  b64x_resbuf u_resbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_fire),
    .list_i      (list),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .head_o      (head),
    .free_o      (buf_free)
  );

  assign out_if.out_byte  = head.data;
  assign out_if.out_valid = head.data_valid;
  assign out_if.out_last  = head.last;

  // codec state: a direction write or the end of a message clears it
  always_comb begin
    st_d = st_q;
    if (cfg_we_i && cfg_idx_i == CFG_DIRECTION) begin
      st_d = '0;
    end else if (step_fire) begin
      if (in_last_q) begin
        st_d = '0;
      end else if (dir_q == DIR_ENCODE) begin
        st_d = enc_st;
      end else begin
        st_d = dec_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
      key_q <= KEY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIRECTION: dir_q <= dir_e'(cfg_wdata_i[0]);
        CFG_MASK_KEY:  key_q <= cfg_wdata_i;
      endcase
    end
  end

  `ASSERT_NEXT(a_last_clears_state, step_fire && in_last_q, st_q == '0, "state left after last item")
  `ASSERT_IMPL(a_esc_only_decode, st_q.esc, dir_q == DIR_DECODE, "escape pending in encode mode")
  `ASSERT_IMPL(a_enc_held_range, dir_q == DIR_ENCODE, st_q.hc != 2'd3, "six held bits in encode mode")

endmodule

`default_nettype wire

// ===== design/b64x_enc.sv =====
// encode step: byte into base64 sextets, padding on last, key mask
`default_nettype none

module b64x_enc (
  input  b64x_pkg::codec_state_t st_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  input  logic [7:0]             key_i,
  output b64x_pkg::char_list_t   chars_o,
  output b64x_pkg::codec_state_t st_o
);
  import b64x_pkg::*;

  logic [NUM_CHARS-1:0][7:0] raw;
  logic [2:0]                n;

  always_comb begin
    raw  = '0;
    n    = 3'd0;
    st_o = '0;
    unique case (st_i.hc)
      2'd0: begin
        raw[0]     = b64_char(data_i[7:2]);
        st_o.hc    = 2'd1;
        st_o.held  = {4'b0000, data_i[1:0]};
        if (last_i) begin
          raw[1] = b64_char({data_i[1:0], 4'b0000});
          raw[2] = PAD_CHAR;
          raw[3] = PAD_CHAR;
          n      = 3'd4;
        end else begin
          n = 3'd1;
        end
      end
      2'd1: begin
        raw[0]     = b64_char({st_i.held[1:0], data_i[7:4]});
        st_o.hc    = 2'd2;
        st_o.held  = {2'b00, data_i[3:0]};
        if (last_i) begin
          raw[1] = b64_char({data_i[3:0], 2'b00});
          raw[2] = PAD_CHAR;
          n      = 3'd3;
        end else begin
          n = 3'd1;
        end
      end
      2'd2: begin
        raw[0] = b64_char({st_i.held[3:0], data_i[7:6]});
        raw[1] = b64_char(data_i[5:0]);
        n      = 3'd2;
      end
      2'd3: begin
        // six held bits never occur while encoding
        n = 3'd0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_CHARS; k++) begin
      chars_o.ch[k] = raw[k] ^ key_i;
    end
    chars_o.cnt = n;
  end

endmodule

`default_nettype wire

// ===== design/b64x_dec.sv =====
// decode step: backslash pairing, key unmask and base64 decode
`default_nettype none

module b64x_dec (
  input  b64x_pkg::codec_state_t st_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  input  logic [7:0]             key_i,
  output b64x_pkg::char_list_t   chars_o,
  output b64x_pkg::codec_state_t st_o
);
  import b64x_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [1:0] hc;
    logic [5:0] held;
  } dec_res_t;

  // one text character into the bit accumulator
  function automatic dec_res_t dec_one(logic en, logic [1:0] hc, logic [5:0] held,
                                       logic [7:0] c, logic [7:0] k);
    sextet_t  s;
    dec_res_t r;
    s      = b64_value(c ^ k);
    r.emit = 1'b0;
    r.data = 8'h00;
    r.hc   = hc;
    r.held = held;
    if (en && s.ok) begin
      unique case (hc)
        2'd0: begin
          r.hc   = 2'd3;
          r.held = s.val;
        end
        2'd1: begin
          r.emit = 1'b1;
          r.data = {held[1:0], s.val};
          r.hc   = 2'd0;
          r.held = 6'd0;
        end
        2'd2: begin
          r.emit = 1'b1;
          r.data = {held[3:0], s.val[5:2]};
          r.hc   = 2'd1;
          r.held = {4'b0000, s.val[1:0]};
        end
        2'd3: begin
          r.emit = 1'b1;
          r.data = {held[5:0], s.val[5:4]};
          r.hc   = 2'd2;
          r.held = {2'b00, s.val[3:0]};
        end
      endcase
    end
    return r;
  endfunction

  logic       is_bs;
  logic       a_en;
  logic       b_en;
  logic [7:0] a_char;
  dec_res_t   r1;
  dec_res_t   r2;

  // a pending backslash goes first, then the current character
  assign is_bs  = (data_i == BACKSLASH);
  assign a_char = (is_bs || st_i.esc) ? BACKSLASH : data_i;
  assign a_en   = !is_bs || st_i.esc || last_i;
  assign b_en   = !is_bs && st_i.esc;

  assign r1 = dec_one(a_en, st_i.hc, st_i.held, a_char, key_i);
  assign r2 = dec_one(b_en, r1.hc, r1.held, data_i, key_i);

  always_comb begin
    chars_o       = '0;
    chars_o.ch[0] = r1.emit ? r1.data : r2.data;
    chars_o.ch[1] = r2.data;
    chars_o.cnt   = {2'b00, r1.emit} + {2'b00, r2.emit};
    st_o.hc       = r2.hc;
    st_o.held     = r2.held;
    st_o.esc      = is_bs && !st_i.esc;
  end

endmodule

`default_nettype wire

// ===== design/b64x_pack.sv =====
// lays characters into result slots, doubles masked backslashes, marks last
`default_nettype none

module b64x_pack (
  input  b64x_pkg::char_list_t chars_i,
  input  logic                 escape_en_i,
  input  logic                 last_i,
  output b64x_pkg::res_list_t  list_o
);
  import b64x_pkg::*;

  logic [1:0] sz  [NUM_CHARS];
  logic [3:0] pos [NUM_CHARS+1];
  logic [2:0] n;

  always_comb begin
    pos[0] = 4'd0;
    for (int k = 0; k < NUM_CHARS; k++) begin
      if (3'(k) < chars_i.cnt) begin
        sz[k] = (escape_en_i && chars_i.ch[k] == BACKSLASH) ? 2'd2 : 2'd1;
      end else begin
        sz[k] = 2'd0;
      end
      pos[k+1] = pos[k] + {2'b00, sz[k]};
    end
  end

  assign n = (pos[NUM_CHARS] > 4'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : pos[NUM_CHARS][2:0];

  always_comb begin
    list_o = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int k = 0; k < NUM_CHARS; k++) begin
        if (sz[k] != 2'd0 && pos[k] == 4'(s)) begin
          list_o.slot[s].data = chars_i.ch[k];
        end
        if (sz[k] == 2'd2 && pos[k] + 4'd1 == 4'(s)) begin
          list_o.slot[s].data = chars_i.ch[k];
        end
      end
      list_o.slot[s].data_valid = (3'(s) < n);
      list_o.slot[s].last       = last_i && (3'(s) == n - 3'd1);
    end
    list_o.cnt = n;
    // a last item with no data leaves a bare end marker
    if (last_i && n == 3'd0) begin
      list_o.slot[0] = '{data: 8'h00, data_valid: 1'b0, last: 1'b1};
      list_o.cnt     = 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64x_resbuf.sv =====
// result register bank: loaded with all results of an item, drained one per cycle while out_ready_i is high
`default_nettype none

module b64x_resbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  b64x_pkg::res_list_t list_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output b64x_pkg::res_t      head_o,
  output logic                free_o
);
  import b64x_pkg::*;

  res_t [NUM_SLOTS-1:0] slots_q;
  logic [2:0]           rem_q, rem_d;
  logic [2:0]           rd_q, rd_d;
  logic                 take;

  assign out_valid_o = (rem_q != 3'd0);
  assign head_o      = slots_q[rd_q];
  assign take        = out_valid_o && out_ready_i;
  // free when empty or the last result leaves this cycle
  assign free_o      = (rem_q == 3'd0) || (take && rem_q == 3'd1);

  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (load_i) begin
      rem_d = list_i.cnt;
      rd_d  = 3'd0;
    end else if (take) begin
      rem_d = rem_q - 3'd1;
      rd_d  = (rem_q == 3'd1) ? 3'd0 : rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      rd_q  <= 3'd0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= list_i.slot;
    end
  end

endmodule

`default_nettype wire
